[rtl/core/eased_tween_generator_macros.svh]
// Assertion macros shared by the tween generator.
`ifndef EASED_TWEEN_GENERATOR_MACROS_SVH
`define EASED_TWEEN_GENERATOR_MACROS_SVH

// Asserts that a condition implies a consequence in the same cycle.
`define ETG_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Asserts that a condition implies a consequence in the next cycle.
`define ETG_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/etg_pkg.sv]
`timescale 1ns / 1ps

package etg_pkg;

    localparam int unsigned LevelW = 32;
    localparam int unsigned DurW   = 16;
    localparam int unsigned TimeW  = 17;
    localparam int unsigned ProgW  = 17;
    localparam int unsigned PropW  = 3;
    localparam int unsigned CfgIdxW = 3;
    localparam logic [TimeW-1:0] TimeMax = '1;
    localparam logic [DurW-1:0] DurReset = 16'd1000;

    typedef enum logic [CfgIdxW-1:0] {
        REG_START = 3'd0,
        REG_END   = 3'd1,
        REG_DUR   = 3'd2,
        REG_EASE  = 3'd3,
        REG_LOOP  = 3'd4,
        REG_PROP  = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        EASE_LINEAR      = 2'd0,
        EASE_CUBIC_IN    = 2'd1,
        EASE_CUBIC_OUT   = 2'd2,
        EASE_CUBIC_INOUT = 2'd3
    } t_ease;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_CHECK  = 3'd1,
        OP_DIV    = 3'd2,
        OP_EASE   = 3'd3,
        OP_INTERP = 3'd4,
        OP_FINISH = 3'd5
    } t_op;

    typedef struct packed {
        t_op  op;
        logic cancel;
        logic [DurW-1:0] elapsed;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic skip;
    } t_stat;

endpackage

[rtl/core/etg_ctrl.sv]
`timescale 1ns / 1ps

module etg_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_kind,
    input  logic [15:0]    i_elapsed,
    output logic           o_ready,
    input  logic           i_out_free,
    input  etg_pkg::t_stat i_stat,
    output etg_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_DIV, S_EASE, S_INTERP, S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    etg_pkg::t_cmd n_cmd;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cmd = '0;
        n_cmd.op = etg_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd.op = etg_pkg::OP_CHECK;
                    n_cmd.cancel = i_kind;
                    n_cmd.elapsed = i_elapsed;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.skip) begin
                    n_state = S_IDLE;
                end else begin
                    n_cmd.op = etg_pkg::OP_DIV;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.done) begin
                    n_cmd.op = etg_pkg::OP_EASE;
                    n_state = S_EASE;
                end
            end
            S_EASE: begin
                if (i_stat.done) begin
                    n_cmd.op = etg_pkg::OP_INTERP;
                    n_state = S_INTERP;
                end
            end
            S_INTERP: begin
                if (i_stat.done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_out_free) begin
                    n_cmd.op = etg_pkg::OP_FINISH;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_cmd <= '0;
        end else begin
            r_state <= n_state;
            o_cmd <= n_cmd;
        end
    end

endmodule

[rtl/core/etg_datapath.sv]
`timescale 1ns / 1ps

module etg_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  etg_pkg::t_cmd        i_cmd,
    output etg_pkg::t_stat       o_stat,
    input  logic signed [31:0]   i_start,
    input  logic signed [31:0]   i_end,
    input  logic [15:0]          i_dur,
    input  etg_pkg::t_ease       i_ease,
    input  logic                 i_loop,
    output logic                 o_res_valid,
    output logic signed [31:0]   o_res_level,
    output logic                 o_res_done,
    output logic                 o_res_restart
);

    logic [etg_pkg::TimeW-1:0] r_time;
    logic signed [31:0]        r_level;
    logic                      r_stopped;
    logic [33:0]               r_rem;
    logic [16:0]               r_quot;
    logic [4:0]                r_cnt;
    logic                      r_busy;
    logic [1:0]                r_phase;
    logic [16:0]               r_base;
    logic [50:0]               r_acc;
    logic [16:0]               r_e;
    logic signed [49:0]        r_prod;
    logic                      r_done;

    logic signed [31:0] w_cur;
    logic               w_up;
    logic               w_cmp;
    logic [17:0]        w_sum;
    logic [etg_pkg::TimeW-1:0] w_tsat;
    logic [17:0]        w_trial;
    logic [16:0]        w_p;
    logic [16:0]        w_q;
    logic               w_inv;
    logic signed [32:0] w_delta;
    logic signed [49:0] w_part;
    logic signed [31:0] w_lvl;
    logic               w_fin;

    assign w_up  = (i_end > i_start);
    assign w_cur = (r_time == '0) ? i_start : r_level;
    assign w_cmp = w_up ? (w_cur >= i_end) : (w_cur <= i_end);
    assign w_sum = {1'b0, r_time} + {2'b0, i_cmd.elapsed};
    assign w_tsat = w_sum[17] ? etg_pkg::TimeMax : w_sum[16:0];
    assign w_trial = {1'b0, r_rem[32:16]} - {2'b0, i_dur};
    assign w_p = r_quot;
    assign w_q = 17'd65536 - r_quot;
    assign w_inv = (i_ease == etg_pkg::EASE_CUBIC_OUT) ||
                   ((i_ease == etg_pkg::EASE_CUBIC_INOUT) && !r_quot[16] && !r_quot[15] ?
                    1'b0 : (i_ease == etg_pkg::EASE_CUBIC_INOUT));
    assign w_delta = 33'(i_end) - 33'(i_start);
    assign w_part = r_prod >>> 16;
    assign w_lvl = 32'(i_start + w_part);
    assign w_fin = w_up ? (w_lvl >= i_end) : (w_lvl <= i_end);

    assign o_stat.done = r_done;
    assign o_stat.skip = (i_cmd.op == etg_pkg::OP_CHECK) &&
                         (i_cmd.cancel || r_stopped || w_cmp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
            r_level <= '0;
            r_stopped <= 1'b0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
            o_res_valid <= 1'b0;
        end else begin
            r_done <= 1'b0;
            o_res_valid <= 1'b0;
            case (i_cmd.op)
                etg_pkg::OP_CHECK: begin
                    if (i_cmd.cancel) r_stopped <= 1'b1;
                    if (!i_cmd.cancel && !r_stopped) begin
                        r_level <= w_cur;
                        if (!w_cmp) r_time <= w_tsat;
                    end
                end
                etg_pkg::OP_DIV: begin
                    r_busy <= 1'b1;
                    r_cnt <= 5'd17;
                    r_quot <= '0;
                    r_rem <= {1'b0, r_time, 16'b0};
                    if (i_dur == '0 || r_time >= {1'b0, i_dur}) begin
                        r_busy <= 1'b0;
                        r_cnt <= '0;
                        r_quot <= 17'd65536;
                        r_done <= 1'b1;
                    end
                end
                etg_pkg::OP_EASE: begin
                    r_phase <= 2'd0;
                    r_busy <= 1'b1;
                    r_base <= w_inv ? w_q : w_p;
                    r_acc <= {34'b0, (w_inv ? w_q : w_p)};
                    if (i_ease == etg_pkg::EASE_LINEAR) begin
                        r_busy <= 1'b0;
                        r_e <= r_quot;
                        r_done <= 1'b1;
                    end
                end
                etg_pkg::OP_INTERP: begin
                    r_prod <= w_delta * $signed({1'b0, r_e});
                    r_done <= 1'b1;
                end
                etg_pkg::OP_FINISH: begin
                    o_res_valid <= 1'b1;
                    o_res_done <= w_fin;
                    o_res_restart <= w_fin && i_loop;
                    o_res_level <= w_fin ? i_end : w_lvl;
                    r_level <= w_fin ? (i_loop ? i_start : i_end) : w_lvl;
                    if (w_fin && i_loop) r_time <= '0;
                end
                default: begin
                    if (r_busy && r_cnt != '0) begin
                        if (!w_trial[17]) begin
                            r_rem <= {w_trial[16:0], r_rem[15:0], 1'b0};
                            r_quot <= {r_quot[15:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[32:0], 1'b0};
                            r_quot <= {r_quot[15:0], 1'b0};
                        end
                        r_cnt <= r_cnt - 5'd1;
                        if (r_cnt == 5'd1) begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end else if (r_busy) begin
                        if (r_phase == 2'd0) begin
                            r_acc <= 51'(r_acc[16:0] * r_base);
                            r_phase <= 2'd1;
                        end else if (r_phase == 2'd1) begin
                            r_acc <= 51'(r_acc[33:0] * r_base);
                            r_phase <= 2'd2;
                        end else begin
                            r_busy <= 1'b0;
                            r_done <= 1'b1;
                            if (i_ease == etg_pkg::EASE_CUBIC_IN)
                                r_e <= 17'(r_acc >> 32);
                            else if (i_ease == etg_pkg::EASE_CUBIC_OUT)
                                r_e <= 17'd65536 - 17'(r_acc >> 32);
                            else if (!w_inv)
                                r_e <= 17'(r_acc >> 30);
                            else
                                r_e <= 17'd65536 - 17'(r_acc >> 30);
                        end
                    end
                end
            endcase
        end
    end

endmodule

[rtl/core/eased_tween_generator.sv]
`timescale 1ns / 1ps
// Eased tween generator: each tick request adds its elapsed milliseconds to the
// running time, and the block returns start + (end - start) * ease(time /
// duration) in signed Q16.16 with the property code, raising done when the end
// value is reached and restarting from zero when looping is enabled. A tick that
// gives a result keeps the input busy until the result is issued, with the time set
// mostly by the 17-step serial divider that forms progress and the three steps of
// the multiplier that cubes it; the linear ease skips the multiplier. Ticks whose
// time has reached the duration skip the divider. A result still waiting on the
// output holds the block before it can issue the next one. Cancel requests and
// ticks that give no result return to idle after the check step.

`include "eased_tween_generator_macros.svh"

module eased_tween_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // elapsed_ms
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // current_level, property_sel, zero fill
    output logic [1:0]  m_axis_tuser,   // done_flag, restarted
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic signed [31:0] r_start, r_end;
    logic [15:0] r_dur;
    etg_pkg::t_ease r_ease;
    logic r_loop;
    logic [2:0] r_prop;
    etg_pkg::t_cmd w_cmd;
    etg_pkg::t_stat w_stat;
    logic w_res_valid, w_res_done, w_res_restart;
    logic signed [31:0] w_res_level;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0; r_end <= '0; r_dur <= etg_pkg::DurReset;
            r_ease <= etg_pkg::EASE_LINEAR; r_loop <= 1'b0; r_prop <= '0;
        end else if (i_cfg_valid) begin
            case (etg_pkg::t_reg_idx'(i_cfg_index))
                etg_pkg::REG_START: r_start <= i_cfg_data;
                etg_pkg::REG_END:   r_end <= i_cfg_data;
                etg_pkg::REG_DUR:   r_dur <= i_cfg_data[15:0];
                etg_pkg::REG_EASE:  r_ease <= etg_pkg::t_ease'(i_cfg_data[1:0]);
                etg_pkg::REG_LOOP:  r_loop <= i_cfg_data[0];
                etg_pkg::REG_PROP:  r_prop <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    etg_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .i_kind(s_axis_tuser), .i_elapsed(s_axis_tdata),
        .o_ready(s_axis_tready), .i_out_free(!m_axis_tvalid || m_axis_tready),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    etg_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_stat(w_stat),
        .i_start(r_start), .i_end(r_end), .i_dur(r_dur), .i_ease(r_ease),
        .i_loop(r_loop), .o_res_valid(w_res_valid), .o_res_level(w_res_level),
        .o_res_done(w_res_done), .o_res_restart(w_res_restart)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (w_res_valid) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata <= {5'b0, r_prop, w_res_level};
            m_axis_tuser <= {w_res_restart, w_res_done};
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    `ETG_ASSERT_IMPL(a_restart_needs_done, i_clk, i_rst_n,
                     m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0],
                     "restart without done")
    `ETG_ASSERT_NEXT(a_no_accept_while_busy, i_clk, i_rst_n,
                     s_axis_tvalid && s_axis_tready, !s_axis_tready,
                     "accepted while busy")
    `ETG_ASSERT_IMPL(a_result_slot_free, i_clk, i_rst_n,
                     w_res_valid, !m_axis_tvalid || $past(m_axis_tready),
                     "result overwrite")

endmodule
